// ===== rtl/box_blur_3x3_rgb_top_defines.svh =====
// assertion macros used by the checker file
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle, masked while in reset
`define BB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent, masked while in reset
`define BB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the cycle after a reset cycle
`define BB_ASSERT_AFTER_RESET(lbl, clk, rstn, cons, msg) \
  lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/boxblur_pkg.sv =====
package boxblur_pkg;

  // default sizes
  localparam int MAX_LINE_PIXELS_DEF = 1024;
  localparam int MAX_LINES_DEF       = 1024;

  // channel and field widths
  localparam int PIX_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

  // register reset values
  localparam int WIDTH_RESET  = 800;
  localparam int HEIGHT_RESET = 600;

  // fixed alpha byte on every result
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // neighbourhood sum and divide by nine as multiply by reciprocal
  localparam int SUM_W       = 12;
  localparam int DIV9_MUL_W  = 13;
  localparam int DIV9_MUL    = 7282;
  localparam int DIV9_SHIFT  = 16;

  // one pixel, red in the lowest byte
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  // one line store word: pixel one line back and two lines back
  typedef struct packed {
    logic [$bits(rgb_t)-1:0] mid;
    logic [$bits(rgb_t)-1:0] up;
  } line_word_t;

  // one window column, index 0 top row, index 2 bottom row
  typedef rgb_t [2:0] column_t;

  // which neighbours lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } nbr_mask_t;

  // per channel neighbourhood sums
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  // floor of s / 9 for s below 2304
  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_MUL_W-1:0] prod;
    prod = (SUM_W + DIV9_MUL_W)'(s) * (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
    return prod[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== rtl/boxblur_ram.sv =====
module boxblur_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/box_blur_3x3_rgb_top.sv =====
// channel  side    handshake              payload
// in       slave   in_tvalid / in_tready  in_tdata pixel, in_tuser flush
// out      master  out_tvalid/out_tready  out_tdata pixel and position, out_tlast frame end
// cfg      slave   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel transaction per clock sustained while out_tready is high, set by the single line
// store ram (one read at accept, one write as the pixel leaves stage 1, per pixel)
// a result passes stage 1, stage 2 and the result register before it shows on out_tvalid
// results trail the input stream by one line plus one pixel of transactions
// rst_n is synchronous: clears counters and valids, dimensions back to 800 x 600
// out_tready low backs up through the stages to in_tready; cfg_ready is always high
module box_blur_3x3_rgb_top #(
  parameter int MAX_LINE_PIXELS = boxblur_pkg::MAX_LINE_PIXELS_DEF,
  parameter int MAX_LINES       = boxblur_pkg::MAX_LINES_DEF,
  localparam int CW = $clog2(MAX_LINE_PIXELS),
  localparam int RW = $clog2(MAX_LINES),
  localparam int OUT_TDATA_W = ((4 * boxblur_pkg::PIX_W + CW + RW + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: in_red, in_green, in_blue
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [3*boxblur_pkg::PIX_W-1:0]     in_tdata,
  // in_tuser: flush
  input  logic                                in_tuser,
  // out_tdata: out_red, out_green, out_blue, out_alpha, out_col, out_row, zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]              out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [boxblur_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [boxblur_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW    = $clog2(MAX_LINE_PIXELS + 1);
  localparam int HW    = $clog2(MAX_LINES + 1);
  localparam int IRW   = $clog2(MAX_LINES + 2);
  localparam int CLW_W = (WW > boxblur_pkg::CFG_DATA_W) ? WW : boxblur_pkg::CFG_DATA_W;
  localparam int CLW_H = (HW > boxblur_pkg::CFG_DATA_W) ? HW : boxblur_pkg::CFG_DATA_W;
  localparam int W_RST = (boxblur_pkg::WIDTH_RESET > MAX_LINE_PIXELS) ?
                         MAX_LINE_PIXELS : boxblur_pkg::WIDTH_RESET;
  localparam int H_RST = (boxblur_pkg::HEIGHT_RESET > MAX_LINES) ?
                         MAX_LINES : boxblur_pkg::HEIGHT_RESET;

  // frame dimensions, already clamped
  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;

  // stream and result positions
  logic [CW-1:0]  icnt_col_r, icnt_col_nxt;
  logic [IRW-1:0] icnt_row_r, icnt_row_nxt;
  logic [CW-1:0]  ocnt_col_r, ocnt_col_nxt;
  logic [RW-1:0]  ocnt_row_r, ocnt_row_nxt;

  // stage 1: accepted pixel, line store data arrives alongside
  logic                     s1_valid_r, s1_valid_nxt;
  boxblur_pkg::rgb_t        s1_pix_r;
  logic [CW-1:0]            s1_col_r;
  logic                     s1_res_r;
  boxblur_pkg::nbr_mask_t   s1_mask_r;
  logic [CW-1:0]            s1_ocol_r;
  logic [RW-1:0]            s1_orow_r;
  logic                     s1_last_r;
  logic                     s1_byp_r;
  boxblur_pkg::line_word_t  s1_bypd_r;

  // window columns one and two pixels back
  boxblur_pkg::column_t     win_r [2];

  // stage 2: neighbourhood sums
  logic                     s2_valid_r, s2_valid_nxt;
  boxblur_pkg::sums_t       s2_sum_r;
  logic [CW-1:0]            s2_col_r;
  logic [RW-1:0]            s2_row_r;
  logic                     s2_last_r;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  boxblur_pkg::rgb_t        res_pix_r;
  logic [CW-1:0]            res_col_r;
  logic [RW-1:0]            res_row_r;
  logic                     res_last_r;

  logic                     in_fire, s1_fire, s2_fire, cfg_fire;
  logic                     col_wrap, started, pix_ok, frame_end, byp_hit;
  boxblur_pkg::nbr_mask_t   mask_now;
  boxblur_pkg::rgb_t        in_pix;
  boxblur_pkg::line_word_t  ram_q, s1_word, ram_wdata;
  boxblur_pkg::column_t     new_col;
  boxblur_pkg::sums_t       s1_sum;
  logic [CLW_W-1:0]         cfg_ext_w;
  logic [CLW_H-1:0]         cfg_ext_h;
  logic [WW-1:0]            cfg_w_clamped;
  logic [HW-1:0]            cfg_h_clamped;

  // handshakes through the stages
  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign s2_fire    = s2_valid_r && (!out_valid_r || out_tready);
  assign s1_fire    = s1_valid_r && (!s1_res_r || !s2_valid_r || s2_fire);
  assign in_tready  = !s1_valid_r || s1_fire;
  assign in_fire    = in_tvalid && in_tready;

  // position decode for the incoming transaction
  assign col_wrap  = (WW'(icnt_col_r) + WW'(1)) >= w_r;
  assign started   = (icnt_row_r >= IRW'(2)) ||
                     ((icnt_row_r == IRW'(1)) && (icnt_col_r != '0));
  assign pix_ok    = !in_tuser && (icnt_row_r < IRW'(h_r));
  assign frame_end = ((HW'(ocnt_row_r) + HW'(1)) == h_r) &&
                     ((WW'(ocnt_col_r) + WW'(1)) == w_r);
  assign mask_now.top   = ocnt_row_r != '0;
  assign mask_now.bot   = (HW'(ocnt_row_r) + HW'(1)) < h_r;
  assign mask_now.left  = ocnt_col_r != '0;
  assign mask_now.right = (WW'(ocnt_col_r) + WW'(1)) < w_r;
  assign in_pix    = pix_ok ? boxblur_pkg::rgb_t'(in_tdata) : '0;

  // register writes clamped to the supported range
  assign cfg_ext_w = CLW_W'(cfg_data);
  assign cfg_ext_h = CLW_H'(cfg_data);
  assign cfg_w_clamped = (cfg_ext_w == '0) ? WW'(1) :
                         (cfg_ext_w > CLW_W'(MAX_LINE_PIXELS)) ? WW'(MAX_LINE_PIXELS) :
                         WW'(cfg_ext_w);
  assign cfg_h_clamped = (cfg_ext_h == '0) ? HW'(1) :
                         (cfg_ext_h > CLW_H'(MAX_LINES)) ? HW'(MAX_LINES) :
                         HW'(cfg_ext_h);

  // dimensions and position counters
  always_comb begin
    logic restart;
    restart      = 1'b0;
    w_nxt        = w_r;
    h_nxt        = h_r;
    icnt_col_nxt = icnt_col_r;
    icnt_row_nxt = icnt_row_r;
    ocnt_col_nxt = ocnt_col_r;
    ocnt_row_nxt = ocnt_row_r;
    if (cfg_fire) begin
      case (cfg_index)
        boxblur_pkg::REG_ACTIVE_WIDTH: begin
          w_nxt   = cfg_w_clamped;
          restart = 1'b1;
        end
        boxblur_pkg::REG_ACTIVE_HEIGHT: begin
          h_nxt   = cfg_h_clamped;
          restart = 1'b1;
        end
        default: ;
      endcase
    end
    if (restart || (in_fire && started && frame_end)) begin
      icnt_col_nxt = '0;
      icnt_row_nxt = '0;
      ocnt_col_nxt = '0;
      ocnt_row_nxt = '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        icnt_col_nxt = '0;
        icnt_row_nxt = icnt_row_r + IRW'(1);
      end else begin
        icnt_col_nxt = icnt_col_r + CW'(1);
      end
      if (started) begin
        if (!mask_now.right) begin
          ocnt_col_nxt = '0;
          ocnt_row_nxt = ocnt_row_r + RW'(1);
        end else begin
          ocnt_col_nxt = ocnt_col_r + CW'(1);
        end
      end
    end
  end

  // stage valids
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    s2_valid_nxt  = (s1_fire && s1_res_r) ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_r);
    out_valid_nxt = s2_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= WW'(W_RST);
      h_r         <= HW'(H_RST);
      icnt_col_r  <= '0;
      icnt_row_r  <= '0;
      ocnt_col_r  <= '0;
      ocnt_row_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      icnt_col_r  <= icnt_col_nxt;
      icnt_row_r  <= icnt_row_nxt;
      ocnt_col_r  <= ocnt_col_nxt;
      ocnt_row_r  <= ocnt_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line store, one word per column holding the two previous lines
  boxblur_ram #(
    .WIDTH ($bits(boxblur_pkg::line_word_t)),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (icnt_col_r),
    .rdata (ram_q)
  );

  // same column written and read in one cycle: forward the write data
  assign byp_hit   = s1_fire && (s1_col_r == icnt_col_r);
  assign s1_word   = s1_byp_r ? s1_bypd_r : ram_q;
  assign ram_wdata = '{mid: s1_pix_r, up: s1_word.mid};

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_pix;
      s1_col_r  <= icnt_col_r;
      s1_res_r  <= started;
      s1_mask_r <= mask_now;
      s1_ocol_r <= ocnt_col_r;
      s1_orow_r <= ocnt_row_r;
      s1_last_r <= frame_end;
      s1_byp_r  <= byp_hit;
      s1_bypd_r <= ram_wdata;
    end
  end

  // newest window column: two lines back, one line back, current
  assign new_col[0] = s1_word.up;
  assign new_col[1] = s1_word.mid;
  assign new_col[2] = s1_pix_r;

  // window shift
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_r[0] <= new_col;
      win_r[1] <= win_r[0];
    end
  end

  // masked neighbourhood sums
  always_comb begin
    boxblur_pkg::column_t cols [3];
    logic [2:0]           row_ok;
    logic [2:0]           col_ok;
    cols[0] = new_col;
    cols[1] = win_r[0];
    cols[2] = win_r[1];
    row_ok  = {s1_mask_r.bot, 1'b1, s1_mask_r.top};
    col_ok  = {s1_mask_r.left, 1'b1, s1_mask_r.right};
    s1_sum  = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (row_ok[r] && col_ok[c]) begin
          s1_sum.red   = s1_sum.red   + boxblur_pkg::SUM_W'(cols[c][r].red);
          s1_sum.green = s1_sum.green + boxblur_pkg::SUM_W'(cols[c][r].green);
          s1_sum.blue  = s1_sum.blue  + boxblur_pkg::SUM_W'(cols[c][r].blue);
        end
      end
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (s1_fire && s1_res_r) begin
      s2_sum_r  <= s1_sum;
      s2_col_r  <= s1_ocol_r;
      s2_row_r  <= s1_orow_r;
      s2_last_r <= s1_last_r;
    end
  end

  // divide by nine into the result register
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      res_pix_r.red   <= boxblur_pkg::div9(s2_sum_r.red);
      res_pix_r.green <= boxblur_pkg::div9(s2_sum_r.green);
      res_pix_r.blue  <= boxblur_pkg::div9(s2_sum_r.blue);
      res_col_r       <= s2_col_r;
      res_row_r       <= s2_row_r;
      res_last_r      <= s2_last_r;
    end
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({res_row_r, res_col_r, boxblur_pkg::ALPHA_OPAQUE,
                                    res_pix_r});
  assign out_tlast  = res_last_r;

endmodule

// ===== rtl/boxblur_checker.sv =====
`include "box_blur_3x3_rgb_top_defines.svh"

module boxblur_checker #(
  parameter int TDATA_W = 56
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast
);

  localparam int PW = boxblur_pkg::PIX_W;

  // a stalled result stays offered
  `BB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result withdrawn while stalled")

  // a stalled result keeps its payload
  `BB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result payload changed while stalled")

  // every result carries opaque alpha
  `BB_ASSERT_NOW(a_alpha, clk, rst_n, out_tvalid, out_tdata[4*PW-1 -: PW] == boxblur_pkg::ALPHA_OPAQUE, "alpha byte not opaque")

  // reset empties the pipeline and leaves the input open
  `BB_ASSERT_AFTER_RESET(a_reset_empty, clk, rst_n, !out_tvalid && in_tready, "pipeline not empty after reset")

endmodule

bind box_blur_3x3_rgb_top boxblur_checker #(
  .TDATA_W (OUT_TDATA_W)
) u_boxblur_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
